### src/blpg_pkg.sv
// Shared types and constants for the Bresenham line pixel generator.
// No dependencies; every other file in src refers to this package by scoped names.
package blpg_pkg;

  localparam int COORD_BITS = 10;
  localparam int COLOR_BITS = 16;
  localparam int DEC_BITS   = COORD_BITS + 3;
  localparam int CMD_DEPTH  = 4;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_TICK = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t                 kind;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;
    logic [COLOR_BITS-1:0] color;
  } item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [COLOR_BITS-1:0] pixel_color;
    logic                  last_pixel;
  } pixel_t;

  typedef struct packed {
    kind_t                 kind;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] abs_dx;
    logic [COORD_BITS-1:0] abs_dy;
    logic                  x_neg;
    logic                  y_neg;
    logic                  x_major;
    logic [COLOR_BITS-1:0] color;
  } cmd_t;

endpackage

### src/blpg_front.sv
// Front end: classifies an incoming word and prepares line setup (signs, deltas, major axis).
// Depends on blpg_pkg.
module blpg_front (
  input  blpg_pkg::item_t item,
  output blpg_pkg::cmd_t  cmd
);

  localparam int CB = blpg_pkg::COORD_BITS;

  logic [CB:0]   dx;
  logic [CB:0]   dy;
  logic [CB:0]   dx_mag;
  logic [CB:0]   dy_mag;
  logic [CB-1:0] abs_dx;
  logic [CB-1:0] abs_dy;

  always_comb begin
    dx     = {1'b0, item.end_x} - {1'b0, item.start_x};
    dy     = {1'b0, item.end_y} - {1'b0, item.start_y};
    dx_mag = dx[CB] ? (~dx + 1'b1) : dx;
    dy_mag = dy[CB] ? (~dy + 1'b1) : dy;
    abs_dx = dx_mag[CB-1:0];
    abs_dy = dy_mag[CB-1:0];

    cmd.kind    = item.kind;
    cmd.start_x = item.start_x;
    cmd.start_y = item.start_y;
    cmd.abs_dx  = abs_dx;
    cmd.abs_dy  = abs_dy;
    cmd.x_neg   = dx[CB];
    cmd.y_neg   = dy[CB];
    cmd.x_major = abs_dx > abs_dy;
    cmd.color   = item.color;
  end

endmodule

### src/blpg_cmd_fifo.sv
// Short command queue between the front end and the line walker.
// Depends on blpg_pkg.
module blpg_cmd_fifo #(
  parameter int DEPTH = blpg_pkg::CMD_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  blpg_pkg::cmd_t wdata,
  output logic           full,
  input  logic           pop,
  output blpg_pkg::cmd_t rdata,
  output logic           empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  blpg_pkg::cmd_t mem [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full && !pop))
    else $error("command queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("command queue underflow");

endmodule

### src/blpg_back.sv
// Back end: holds the active line, walks it one pixel per tick word, and buffers the result.
// Depends on blpg_pkg.
module blpg_back (
  input  logic            clk,
  input  logic            rst,
  input  blpg_pkg::cmd_t  cmd,
  input  logic            cmd_empty,
  output logic            cmd_pop,
  output blpg_pkg::pixel_t pixel,
  output logic            empty,
  input  logic            pop
);

  localparam int CB = blpg_pkg::COORD_BITS;
  localparam int DB = blpg_pkg::DEC_BITS;

  logic                           active;
  logic [CB-1:0]                  cur_x;
  logic [CB-1:0]                  cur_y;
  logic                           step_x_neg;
  logic                           step_y_neg;
  logic                           x_major;
  logic [CB:0]                    twice_dx;
  logic [CB:0]                    twice_dy;
  logic [DB-1:0]                  decision;
  logic [CB-1:0]                  remaining;
  logic [blpg_pkg::COLOR_BITS-1:0] line_color;
  logic                           out_valid;

  logic          is_load;
  logic          out_free;
  logic          emit;
  logic          last;
  logic          minor_step;
  logic [CB-1:0] x_stepped;
  logic [CB-1:0] y_stepped;
  logic [DB-1:0] decision_next;
  logic [DB-1:0] load_decision;

  always_comb begin
    is_load    = (cmd.kind == blpg_pkg::KIND_LOAD);
    out_free   = !out_valid || pop;
    cmd_pop    = !cmd_empty && (is_load || !active || out_free);
    emit       = !cmd_empty && !is_load && active && out_free;
    last       = (remaining == '0);
    minor_step = !decision[DB-1];
    x_stepped  = step_x_neg ? cur_x - 1'b1 : cur_x + 1'b1;
    y_stepped  = step_y_neg ? cur_y - 1'b1 : cur_y + 1'b1;
    if (x_major) begin
      decision_next = decision + {2'b00, twice_dy}
                    - (minor_step ? {2'b00, twice_dx} : '0);
    end else begin
      decision_next = decision + {2'b00, twice_dx}
                    - (minor_step ? {2'b00, twice_dy} : '0);
    end
    if (cmd.x_major) begin
      load_decision = {2'b00, cmd.abs_dy, 1'b0} - {3'b000, cmd.abs_dx};
    end else begin
      load_decision = {2'b00, cmd.abs_dx, 1'b0} - {3'b000, cmd.abs_dy};
    end
  end

  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end
      if (cmd_pop && is_load) begin
        active <= 1'b1;
      end else if (emit && last) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && is_load) begin
      cur_x      <= cmd.start_x;
      cur_y      <= cmd.start_y;
      step_x_neg <= cmd.x_neg;
      step_y_neg <= cmd.y_neg;
      x_major    <= cmd.x_major;
      twice_dx   <= {cmd.abs_dx, 1'b0};
      twice_dy   <= {cmd.abs_dy, 1'b0};
      decision   <= load_decision;
      remaining  <= cmd.x_major ? cmd.abs_dx : cmd.abs_dy;
      line_color <= cmd.color;
    end else if (emit && !last) begin
      decision  <= decision_next;
      remaining <= remaining - 1'b1;
      if (x_major) begin
        cur_x <= x_stepped;
        if (minor_step) begin
          cur_y <= y_stepped;
        end
      end else begin
        cur_y <= y_stepped;
        if (minor_step) begin
          cur_x <= x_stepped;
        end
      end
    end
    if (emit) begin
      pixel.pixel_x     <= cur_x;
      pixel.pixel_y     <= cur_y;
      pixel.pixel_color <= line_color;
      pixel.last_pixel  <= last;
    end
  end

  a_load_activates: assert property (@(posedge clk) disable iff (rst)
    (cmd_pop && is_load) |=> (active && cur_x == $past(cmd.start_x)))
    else $error("load did not start a line");
  a_last_ends_line: assert property (@(posedge clk) disable iff (rst)
    (emit && last) |=> !active)
    else $error("line still active after its last pixel");
  a_emit_keeps_point: assert property (@(posedge clk) disable iff (rst)
    emit |=> (out_valid && pixel.pixel_x == $past(cur_x) && pixel.pixel_y == $past(cur_y)))
    else $error("emitted pixel does not match walker point");
  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    !(emit && out_valid && !pop))
    else $error("result slot overwritten");

endmodule

### src/bresenham_line_pixel_generator.sv
// Bresenham line pixel generator: load words set up a line, tick words emit one pixel each.
// Accepts one word per cycle unless full; a tick is queued, then its pixel is registered.
// Throughput is one word per cycle while the result slot is popped, set by the walker step.
// The command queue decouples intake from the walker, so intake stalls only when it fills.
// Reset is synchronous: queue and result slot empty, no line active.
// Depends on blpg_pkg, blpg_front, blpg_cmd_fifo and blpg_back.
module bresenham_line_pixel_generator #(
  parameter int CMD_DEPTH = blpg_pkg::CMD_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  blpg_pkg::item_t  item,
  output logic             full,
  input  logic             pop,
  output blpg_pkg::pixel_t pixel,
  output logic             empty
);

  blpg_pkg::cmd_t front_cmd;
  blpg_pkg::cmd_t head_cmd;
  logic           cmd_empty;
  logic           cmd_pop;
  logic           cmd_push;

  assign cmd_push = push && !full;

  blpg_front u_front (
    .item (item),
    .cmd  (front_cmd)
  );

  blpg_cmd_fifo #(
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .wdata (front_cmd),
    .full  (full),
    .pop   (cmd_pop),
    .rdata (head_cmd),
    .empty (cmd_empty)
  );

  blpg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (head_cmd),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .pixel     (pixel),
    .empty     (empty),
    .pop       (pop)
  );

endmodule
